>>> rtl/kmg_pkg.sv
// package for the key matrix ghosting block: sizes, a mask and the command struct
// used by the controller, the datapath and the top level; no dependencies

package kmg_pkg;

  localparam int ROWS     = 8;
  localparam int COLS     = 8;
  localparam int KeyBits  = 64;
  localparam int RowW     = 3;
  localparam int KeyW     = 6;
  localparam int PortW    = 8;
  localparam int KEYS     = ROWS * COLS;

  localparam logic [KeyBits-1:0] UsedMask =
      (KEYS >= KeyBits) ? {KeyBits{1'b1}} : ((64'd1 << KEYS) - 64'd1);

  localparam logic [RowW-1:0] LastRowA = RowW'(ROWS - 2);
  localparam logic [RowW-1:0] LastRowB = RowW'(ROWS - 1);
  localparam logic [KeyW-1:0] LastKey  = KeyW'(KEYS - 1);

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdRead = 1'b1;

  typedef struct packed {
    logic            load;
    logic            read_init;
    logic            ghost_step;
    logic            scan_step;
    logic            result_load;
    logic [RowW-1:0] row_a;
    logic [RowW-1:0] row_b;
    logic [KeyW-1:0] key_idx;
  } kmg_cmd_t;

endpackage

>>> rtl/kmg_if.sv
// valid/ready channel interfaces for the request and result transfers
// depends on kmg_pkg

interface kmg_req_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [kmg_pkg::KeyBits-1:0] pressed_keys;
  logic [kmg_pkg::PortW-1:0]   port_a_drive;
  logic [kmg_pkg::PortW-1:0]   port_b_drive;
  logic [kmg_pkg::PortW-1:0]   joystick_a_lines;
  logic [kmg_pkg::PortW-1:0]   joystick_b_lines;

  modport source (output valid, command, pressed_keys, port_a_drive, port_b_drive,
                  joystick_a_lines, joystick_b_lines, input ready);
  modport sink (input valid, command, pressed_keys, port_a_drive, port_b_drive,
                joystick_a_lines, joystick_b_lines, output ready);
endinterface

interface kmg_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [kmg_pkg::PortW-1:0] port_a_lines;
  logic [kmg_pkg::PortW-1:0] port_b_lines;
  logic                      any_key_down;

  modport source (output valid, port_a_lines, port_b_lines, any_key_down, input ready);
  modport sink (input valid, port_a_lines, port_b_lines, any_key_down, output ready);
endinterface

>>> rtl/kmg_ctrl.sv
// controller: sequences the ghost pair pass and the key scan, owns the handshakes
// depends on kmg_pkg

module kmg_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_command,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output kmg_pkg::kmg_cmd_t cmd
);
  import kmg_pkg::*;

  typedef enum logic [1:0] {IDLE, GHOST, SCAN, FINISH} state_t;

  state_t          state;
  logic [RowW-1:0] row_a;
  logic [RowW-1:0] row_b;
  logic [KeyW-1:0] key_idx;
  logic            accept;
  logic            emit;

  assign in_ready = (state == IDLE);
  assign accept   = in_valid && in_ready;
  assign emit     = (state == FINISH) && (!out_valid || out_ready);

  always_comb begin
    cmd             = '0;
    cmd.load        = accept && (in_command == CmdLoad);
    cmd.read_init   = accept && (in_command == CmdRead);
    cmd.ghost_step  = (state == GHOST);
    cmd.scan_step   = (state == SCAN);
    cmd.result_load = emit;
    cmd.row_a       = row_a;
    cmd.row_b       = row_b;
    cmd.key_idx     = key_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      row_a     <= '0;
      row_b     <= '0;
      key_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          row_a   <= '0;
          row_b   <= RowW'(1);
          key_idx <= '0;
          if (accept) begin
            state <= (in_command == CmdLoad) ? GHOST : SCAN;
          end
        end
        GHOST: begin
          if (row_a == LastRowA && row_b == LastRowB) begin
            state <= FINISH;
          end else if (row_b == LastRowB) begin
            row_a <= row_a + RowW'(1);
            row_b <= row_a + RowW'(2);
          end else begin
            row_b <= row_b + RowW'(1);
          end
        end
        SCAN: begin
          if (key_idx == LastKey) begin
            state <= FINISH;
          end else begin
            key_idx <= key_idx + KeyW'(1);
          end
        end
        FINISH: begin
          if (emit) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/kmg_dp.sv
// datapath: key matrix register, ghost merge of one row pair, one-key line scan
// and the result register; depends on kmg_pkg

module kmg_dp (
  input  logic                        clk,
  input  kmg_pkg::kmg_cmd_t           cmd,
  input  logic [kmg_pkg::KeyBits-1:0] pressed_keys,
  input  logic [kmg_pkg::PortW-1:0]   port_a_drive,
  input  logic [kmg_pkg::PortW-1:0]   port_b_drive,
  input  logic [kmg_pkg::PortW-1:0]   joystick_a_lines,
  input  logic [kmg_pkg::PortW-1:0]   joystick_b_lines,
  input  logic                        rst,
  output logic [kmg_pkg::PortW-1:0]   port_a_lines,
  output logic [kmg_pkg::PortW-1:0]   port_b_lines,
  output logic                        any_key_down
);
  import kmg_pkg::*;

  logic [KeyBits-1:0] key_matrix;
  logic [KeyBits-1:0] key_matrix_next;
  logic [PortW-1:0]   pa;
  logic [PortW-1:0]   pb;
  logic [PortW-1:0]   pa_next;
  logic [PortW-1:0]   pb_next;
  logic [COLS-1:0]    row_a_bits;
  logic [COLS-1:0]    row_b_bits;
  logic [RowW-1:0]    scan_row;
  logic [RowW-1:0]    scan_col;

  assign row_a_bits = key_matrix[cmd.row_a * COLS +: COLS];
  assign row_b_bits = key_matrix[cmd.row_b * COLS +: COLS];
  assign scan_row   = cmd.key_idx[KeyW-1:RowW];
  assign scan_col   = cmd.key_idx[RowW-1:0];

  always_comb begin
    key_matrix_next = key_matrix;
    if (cmd.load) begin
      key_matrix_next = pressed_keys & UsedMask;
    end else if (cmd.ghost_step && |(row_a_bits & row_b_bits)) begin
      key_matrix_next[cmd.row_a * COLS +: COLS] = row_a_bits | row_b_bits;
      key_matrix_next[cmd.row_b * COLS +: COLS] = row_a_bits | row_b_bits;
    end
  end

  always_comb begin
    pa_next = pa;
    pb_next = pb;
    if (cmd.load) begin
      pa_next = '0;
      pb_next = '0;
    end else if (cmd.read_init) begin
      pa_next = port_a_drive & joystick_a_lines;
      pb_next = port_b_drive & joystick_b_lines;
    end else if (cmd.scan_step && key_matrix[cmd.key_idx]
                 && (!pa[scan_row] || !pb[scan_col])) begin
      pa_next[scan_row] = 1'b0;
      pb_next[scan_col] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_matrix <= '0;
    end else begin
      key_matrix <= key_matrix_next;
    end
  end

  always_ff @(posedge clk) begin
    pa <= pa_next;
    pb <= pb_next;
    if (cmd.result_load) begin
      port_a_lines <= pa;
      port_b_lines <= pb;
      any_key_down <= |key_matrix;
    end
  end

endmodule

>>> rtl/keyboard_matrix_ghosting.sv
// key matrix with ghosting: a load takes 28 pair steps (ROWS*(ROWS-1)/2), result
// registered after the last pair step; a read scans 64 keys, result registered after the last key
// one item at a time: ready again the cycle after the result register is loaded
// a load does a single ghost merge per cycle, a read does a one-key scan step per cycle
// synchronous reset clears the key matrix (no keys down), the state and the output valid
// depends on kmg_pkg, kmg_if, kmg_ctrl, kmg_dp

module keyboard_matrix_ghosting (
  input logic      clk,
  input logic      rst,
  kmg_req_if.sink  req,
  kmg_rsp_if.source rsp
);
  import kmg_pkg::*;

  kmg_cmd_t cmd;

  kmg_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_command (req.command),
    .in_ready   (req.ready),
    .out_ready  (rsp.ready),
    .out_valid  (rsp.valid),
    .cmd        (cmd)
  );

  kmg_dp u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .pressed_keys     (req.pressed_keys),
    .port_a_drive     (req.port_a_drive),
    .port_b_drive     (req.port_b_drive),
    .joystick_a_lines (req.joystick_a_lines),
    .joystick_b_lines (req.joystick_b_lines),
    .rst              (rst),
    .port_a_lines     (rsp.port_a_lines),
    .port_b_lines     (rsp.port_b_lines),
    .any_key_down     (rsp.any_key_down)
  );

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while an item is in progress");

  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.read_init, cmd.ghost_step, cmd.scan_step, cmd.result_load}))
    else $error("more than one datapath command at once");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.result_load |=> rsp.valid)
    else $error("result loaded but not presented");

  a_no_load_over_pending: assert property (@(posedge clk) disable iff (rst)
    cmd.result_load |-> (!rsp.valid || rsp.ready))
    else $error("result register overwritten before transfer");

endmodule

>>> bench/keyboard_matrix_ghosting_tb.sv
// testbench for keyboard_matrix_ghosting: directed and random load and read transfers
// checked against an in-bench model of the ghost merge and the port line scan
// depends on kmg_pkg, kmg_if and the keyboard_matrix_ghosting rtl
`timescale 1ns / 100ps

module keyboard_matrix_ghosting_tb;
  import kmg_pkg::*;

  localparam int LIMIT     = 1_000_000;
  localparam int RAND_ITEMS = 1500;
  localparam int HOLD_AT   = 2000;
  localparam int HOLD_LEN  = 400;
  localparam int CALM_LO   = 30000;
  localparam int CALM_HI   = 50000;
  localparam int DRAIN     = 100;

  typedef struct {
    logic               command;
    logic [KeyBits-1:0] keys;
    logic [PortW-1:0]   a_drive;
    logic [PortW-1:0]   b_drive;
    logic [PortW-1:0]   a_joy;
    logic [PortW-1:0]   b_joy;
  } key_event_t;

  typedef struct {
    logic [PortW-1:0] a_lines;
    logic [PortW-1:0] b_lines;
    logic             any_down;
  } port_levels_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cyc = 0;
  int   errors = 0;
  logic req_taken = 1'b0;
  int   hold_cnt = 0;

  logic [KeyBits-1:0] matrix_shadow = '0;
  key_event_t   key_events_q[$];
  port_levels_t port_lines_q[$];

  kmg_req_if req ();
  kmg_rsp_if rsp ();

  keyboard_matrix_ghosting dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [KeyBits-1:0] rand_keys();
    return {$urandom, $urandom};
  endfunction

  function automatic logic take_break();
    return (cyc < CALM_LO || cyc >= CALM_HI) && ($urandom_range(99) < 17);
  endfunction

  function automatic logic [KeyBits-1:0] merge_ghost_rows(input logic [KeyBits-1:0] keys);
    logic [KeyBits-1:0] m;
    logic [PortW-1:0]   ra_bits;
    logic [PortW-1:0]   rb_bits;
    m = keys & UsedMask;
    for (int ra = 0; ra < ROWS - 1; ra++) begin
      for (int rb = ra + 1; rb < ROWS; rb++) begin
        ra_bits = m[ra*COLS +: COLS];
        rb_bits = m[rb*COLS +: COLS];
        if ((ra_bits & rb_bits) != '0) begin
          m[ra*COLS +: COLS] = ra_bits | rb_bits;
          m[rb*COLS +: COLS] = ra_bits | rb_bits;
        end
      end
    end
    return m;
  endfunction

  function automatic port_levels_t resolve_ports(input key_event_t ev,
                                                 input logic [KeyBits-1:0] m);
    port_levels_t r;
    r.a_lines = ev.a_drive & ev.a_joy;
    r.b_lines = ev.b_drive & ev.b_joy;
    for (int n = 0; n < ROWS * COLS; n++) begin
      if (m[n] && (!r.a_lines[n / COLS] || !r.b_lines[n % COLS])) begin
        r.a_lines[n / COLS] = 1'b0;
        r.b_lines[n % COLS] = 1'b0;
      end
    end
    r.any_down = (m != '0);
    return r;
  endfunction

  function automatic void add_load(input logic [KeyBits-1:0] keys);
    key_event_t ev;
    ev.command = CmdLoad;
    ev.keys    = keys;
    ev.a_drive = 8'($urandom);
    ev.b_drive = 8'($urandom);
    ev.a_joy   = 8'($urandom);
    ev.b_joy   = 8'($urandom);
    key_events_q.push_back(ev);
  endfunction

  function automatic void add_read(input logic [PortW-1:0] pa, input logic [PortW-1:0] pb,
                                   input logic [PortW-1:0] ja, input logic [PortW-1:0] jb);
    key_event_t ev;
    ev.command = CmdRead;
    ev.keys    = rand_keys();
    ev.a_drive = pa;
    ev.b_drive = pb;
    ev.a_joy   = ja;
    ev.b_joy   = jb;
    key_events_q.push_back(ev);
  endfunction

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  // monitor: predict on request transfer, check on result transfer
  always @(posedge clk) begin : mon
    port_levels_t want;
    port_levels_t got;
    key_event_t   ev;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req.valid && req.ready;
      if (req.valid && req.ready) begin
        ev.command = req.command;
        ev.keys    = req.pressed_keys;
        ev.a_drive = req.port_a_drive;
        ev.b_drive = req.port_b_drive;
        ev.a_joy   = req.joystick_a_lines;
        ev.b_joy   = req.joystick_b_lines;
        if (ev.command == CmdLoad) begin
          matrix_shadow = merge_ghost_rows(ev.keys);
          want.a_lines  = '0;
          want.b_lines  = '0;
          want.any_down = (matrix_shadow != '0);
        end else begin
          want = resolve_ports(ev, matrix_shadow);
        end
        port_lines_q.push_back(want);
      end
      if (rsp.valid && rsp.ready) begin
        got.a_lines  = rsp.port_a_lines;
        got.b_lines  = rsp.port_b_lines;
        got.any_down = rsp.any_key_down;
        if (port_lines_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: a=%h b=%h any=%b",
                     got.a_lines, got.b_lines, got.any_down);
        end else begin
          want = port_lines_q.pop_front();
          if (got.a_lines !== want.a_lines || got.b_lines !== want.b_lines ||
              got.any_down !== want.any_down) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected a=%h b=%h any=%b, got a=%h b=%h any=%b",
                       want.a_lines, want.b_lines, want.any_down,
                       got.a_lines, got.b_lines, got.any_down);
          end
        end
      end
    end
  end

  // driver: next transfer offered after the previous one is taken
  always @(negedge clk) begin : drv
    key_event_t ev;
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req_taken) begin
      if (key_events_q.size() != 0 && !take_break()) begin
        ev = key_events_q.pop_front();
        req.valid            <= 1'b1;
        req.command          <= ev.command;
        req.pressed_keys     <= ev.keys;
        req.port_a_drive     <= ev.a_drive;
        req.port_b_drive     <= ev.b_drive;
        req.joystick_a_lines <= ev.a_joy;
        req.joystick_b_lines <= ev.b_joy;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // result sink with random stalls and one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      hold_cnt  <= 0;
    end else if (cyc == HOLD_AT) begin
      rsp.ready <= 1'b0;
      hold_cnt  <= HOLD_LEN;
    end else if (hold_cnt != 0) begin
      rsp.ready <= 1'b0;
      hold_cnt  <= hold_cnt - 1;
    end else begin
      rsp.ready <= !take_break();
    end
  end

  initial begin
    wait (cyc == LIMIT);
    $display("keyboard_matrix_ghosting_tb failed");
    $finish;
  end

  initial begin : stim
    logic [KeyBits-1:0] keys;
    logic [PortW-1:0]   pa;
    logic [PortW-1:0]   pb;
    logic [PortW-1:0]   ja;
    logic [PortW-1:0]   jb;
    int                 kind;
    req.valid            = 1'b0;
    req.command          = CmdLoad;
    req.pressed_keys     = '0;
    req.port_a_drive     = '0;
    req.port_b_drive     = '0;
    req.joystick_a_lines = '0;
    req.joystick_b_lines = '0;
    rsp.ready            = 1'b0;

    // directed
    add_read(8'hff, 8'hff, 8'hff, 8'hff);
    add_read(8'h00, 8'h00, 8'h00, 8'h00);
    add_read(8'ha5, 8'h5a, 8'hff, 8'h0f);
    add_load('0);
    add_read(8'hfe, 8'hff, 8'hff, 8'hff);
    add_load(64'h1);
    add_read(8'hfe, 8'hff, 8'hff, 8'hff);
    add_read(8'hff, 8'hff, 8'hff, 8'hfe);
    add_load(64'h8000_0000_0000_0000);
    add_read(8'h7f, 8'hff, 8'hff, 8'hff);
    add_read(8'hff, 8'hff, 8'h7f, 8'hff);
    add_load(64'h0000_0000_0000_0103);
    add_read(8'hfd, 8'hff, 8'hff, 8'hff);
    add_load('1);
    add_read(8'hfe, 8'hff, 8'hff, 8'hff);
    add_read(8'hff, 8'hff, 8'hff, 8'hff);
    add_load(64'h8040_2010_0804_0201);
    add_read(8'hf7, 8'hff, 8'hff, 8'hff);
    add_load(64'h0000_0000_0004_0603);
    add_read(8'hfb, 8'hff, 8'hff, 8'hff);
    add_read(8'hff, 8'h00, 8'hff, 8'hff);
    add_read(8'h00, 8'hff, 8'hff, 8'hff);
    add_load('0);
    add_read(8'h55, 8'haa, 8'hff, 8'hff);

    // random
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if ($urandom_range(99) < 25) begin
        kind = $urandom_range(9);
        if (kind == 0) begin
          keys = '0;
        end else if (kind <= 5) begin
          keys = '0;
          repeat ($urandom_range(1, 5)) keys[$urandom_range(KeyBits - 1)] = 1'b1;
        end else if (kind <= 7) begin
          keys = rand_keys() & rand_keys();
        end else begin
          keys = rand_keys();
        end
        add_load(keys);
      end else begin
        kind = $urandom_range(9);
        pa = 8'hff;
        pb = 8'hff;
        ja = ($urandom_range(3) == 0) ? 8'($urandom) : 8'hff;
        jb = ($urandom_range(3) == 0) ? 8'($urandom) : 8'hff;
        if (kind <= 4) begin
          pa = ~(8'h01 << $urandom_range(7));
        end else if (kind <= 6) begin
          pb = ~(8'h01 << $urandom_range(7));
        end else begin
          pa = 8'($urandom);
          pb = 8'($urandom);
          ja = 8'($urandom);
          jb = 8'($urandom);
        end
        add_read(pa, pb, ja, jb);
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (!(key_events_q.size() == 0 && !req.valid && port_lines_q.size() == 0))
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (errors == 0 && port_lines_q.size() == 0)
      $display("keyboard_matrix_ghosting_tb passed");
    else
      $display("keyboard_matrix_ghosting_tb failed");
    $finish;
  end

endmodule

>>> files.f
rtl/kmg_pkg.sv
rtl/kmg_if.sv
rtl/kmg_ctrl.sv
rtl/kmg_dp.sv
rtl/keyboard_matrix_ghosting.sv
bench/keyboard_matrix_ghosting_tb.sv
